>>> rtl/flc_pkg.sv
// Package with the word types, codes and default sizes of the full linear convolution core.
package flc_pkg;

	localparam int DEF_MAX_TAPS     = 32;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEF_WIDTH   = 16;

	localparam int VALUE_WIDTH = 16;
	localparam int INDEX_WIDTH = 5;
	localparam int TAPS_WIDTH  = 6;
	localparam int Y_WIDTH     = 37;

	typedef enum logic {
		FUNC_COEF   = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	typedef struct packed {
		func_t                         func;
		logic [INDEX_WIDTH-1:0]        coef_index;
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          last_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [Y_WIDTH-1:0] y_value;
		logic                      last_out;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic clr;
		logic vld;
		logic zero;
	} mac_ctl_t;

endpackage

>>> rtl/flc_mac.sv
// Shared multiply-accumulate unit with a product register and a full precision accumulator.
module flc_mac #(
	parameter int COEF_WIDTH   = flc_pkg::DEF_COEF_WIDTH,
	parameter int SAMPLE_WIDTH = flc_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  flc_pkg::mac_ctl_t                  ctl,
	input  logic signed [COEF_WIDTH-1:0]       coef,
	input  logic signed [SAMPLE_WIDTH-1:0]     samp,
	output logic signed [flc_pkg::Y_WIDTH-1:0] acc,
	output logic                               busy
);
	import flc_pkg::*;

	localparam int PW = COEF_WIDTH + SAMPLE_WIDTH;

	logic signed [PW-1:0]      prod_s2;
	logic                      v_s2;
	logic signed [Y_WIDTH-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.zero) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= coef * samp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s2 <= ctl.vld;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + Y_WIDTH'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s2;

endmodule

>>> rtl/full_linear_convolution_core.sv
// Top level of the full linear convolution core: coefficient and delay line memories and tap sequencer.
// Each output word is one pass over the taps, through the multiply-accumulate to the output register.
// A sample gives one word; a sample marked last gives taps words.
// The rate is set by the single shared multiply-accumulate.
// Reset clears the control state, sets the tap count to 1 and makes the delay line read as zero.
// The coefficient memory is not cleared and holds nothing meaningful until written.
module full_linear_convolution_core #(
	parameter int MAX_TAPS     = flc_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_WIDTH = flc_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = flc_pkg::DEF_COEF_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  flc_pkg::in_word_t                 in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output flc_pkg::out_word_t                out_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [flc_pkg::TAPS_WIDTH-1:0]    cfg_data
);
	import flc_pkg::*;

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TW = $clog2(MAX_TAPS + 1);

	logic signed [COEF_WIDTH-1:0]   kern_mem [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] line_mem [MAX_TAPS];

	state_t                   state_q, state_d;
	logic [TAPS_WIDTH-1:0]    tap_count_q;
	logic [TW-1:0]            eff_taps;
	logic [TW-1:0]            taps_q, k_q, tail_q;
	logic [AW-1:0]            wp_q, wp_next, rp_q, rp_prev;
	logic                     last_q;
	logic [MAX_TAPS-1:0]      vld_q;
	logic                     v_s1, zero_s1;
	logic signed [COEF_WIDTH-1:0]   coef_s1;
	logic signed [SAMPLE_WIDTH-1:0] samp_s1;
	logic                     in_fire, smp_fire, coef_fire, coef_ok;
	logic                     issue, issue_last, acc_done, out_load;
	logic                     out_valid_q;
	out_word_t                out_word_q;
	mac_ctl_t                 mac_ctl;
	logic signed [Y_WIDTH-1:0] acc;
	logic                     mac_busy;

	always_comb begin
		if (tap_count_q == '0) begin
			eff_taps = TW'(1);
		end else if (7'(tap_count_q) > 7'(MAX_TAPS)) begin
			eff_taps = TW'(MAX_TAPS);
		end else begin
			eff_taps = TW'(tap_count_q);
		end
	end

	assign wp_next = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
	assign rp_prev = (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - AW'(1);

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign smp_fire   = in_fire && (in_word.func == FUNC_SAMPLE);
	assign coef_fire  = in_fire && (in_word.func == FUNC_COEF);
	assign coef_ok    = 7'(in_word.coef_index) < 7'(MAX_TAPS);
	assign issue      = (state_q == ST_RUN);
	assign issue_last = issue && (k_q == taps_q - TW'(1));
	assign acc_done   = (state_q == ST_DRAIN) && !v_s1 && !mac_busy;
	assign out_load   = acc_done && (!out_valid_q || out_ready);
	assign cfg_ready  = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (smp_fire) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_load) begin
					state_d = (tail_q != '0) ? ST_RUN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAPS_WIDTH'(1);
			taps_q      <= TW'(1);
			k_q         <= '0;
			tail_q      <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			last_q      <= 1'b0;
			vld_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_count_q <= cfg_data;
			end
			v_s1 <= issue;
			if (smp_fire) begin
				taps_q        <= eff_taps;
				tail_q        <= in_word.last_sample ? eff_taps - TW'(1) : '0;
				last_q        <= in_word.last_sample;
				wp_q          <= wp_next;
				rp_q          <= wp_next;
				k_q           <= '0;
				vld_q[wp_next] <= 1'b1;
			end else if (issue) begin
				k_q  <= k_q + TW'(1);
				rp_q <= rp_prev;
			end else if (out_load) begin
				if (tail_q != '0) begin
					tail_q         <= tail_q - TW'(1);
					wp_q           <= wp_next;
					rp_q           <= wp_next;
					k_q            <= '0;
					vld_q[wp_next] <= 1'b0;
				end else if (last_q) begin
					vld_q <= '0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (coef_fire && coef_ok) begin
			kern_mem[AW'(in_word.coef_index)] <= COEF_WIDTH'(in_word.value);
		end
		coef_s1 <= kern_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (smp_fire) begin
			line_mem[wp_next] <= SAMPLE_WIDTH'(in_word.value);
		end
		samp_s1 <= line_mem[rp_q];
		zero_s1 <= !vld_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q.y_value  <= acc;
			out_word_q.last_out <= last_q && (tail_q == '0);
		end
	end

	assign mac_ctl.clr  = smp_fire || (out_load && (tail_q != '0));
	assign mac_ctl.vld  = v_s1;
	assign mac_ctl.zero = zero_s1;

	flc_mac #(
		.COEF_WIDTH   (COEF_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_s1),
		.samp   (samp_s1),
		.acc    (acc),
		.busy   (mac_busy)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
